### hw/rtl/assert_macros.svh
// Assertion helpers used by the checker file hw/rtl/qrv_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clk edge, muted while reset is low.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same check, but also evaluated while reset is held.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hw/rtl/qrv_pkg.sv
`default_nettype none
package qrv_pkg;
  localparam int VEC_WIDTH_DEF  = 24;
  localparam int QUAT_WIDTH_DEF = 16;
  localparam int NUM_AXES       = 3;
  localparam int NUM_QUAT       = 4;
  localparam int NUM_MAT        = NUM_AXES * NUM_AXES;
endpackage
`default_nettype wire

### hw/rtl/quat_rotate_vector.sv
// Stages in order: matrix, mac, restoring divider, output register.
// Throughput: one request per cycle; the whole pipe advances together and
// holds while a result waits at the output register with out_tready low.
// Depth is set by the restoring divider, one quotient bit per stage.
// Reset (rst_n low, synchronous) clears every stage valid; data is not cleared.
`default_nettype none
module quat_rotate_vector #(
  parameter int VEC_WIDTH  = qrv_pkg::VEC_WIDTH_DEF,
  parameter int QUAT_WIDTH = qrv_pkg::QUAT_WIDTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  // request side
  input  wire logic in_tvalid,
  output logic      in_tready,
  // low to high: quat_x, quat_y, quat_z, quat_w, vec_x, vec_y, vec_z, zero pad
  input  wire logic [((4*QUAT_WIDTH+3*VEC_WIDTH+7)/8)*8-1:0] in_tdata,
  // result side
  output logic      out_tvalid,
  input  wire logic out_tready,
  // low to high: rot_x, rot_y, rot_z, zero pad
  output logic [((3*VEC_WIDTH+7)/8)*8-1:0] out_tdata,
  // low to high: zero_quat, saturated
  output logic [1:0] out_tuser
);
  import qrv_pkg::*;

  localparam int RW    = 2 * QUAT_WIDTH + VEC_WIDTH + 6;   // dividend/remainder
  localparam int DW    = 2 * QUAT_WIDTH + 2;               // divisor 2*n2
  localparam int QB    = VEC_WIDTH + 2;                    // quotient bits
  localparam int OUT_W = ((3*VEC_WIDTH+7)/8)*8;
  localparam int VBASE = 4 * QUAT_WIDTH;

  // Global advance: the pipe moves unless the output holds an untaken result.
  logic adv;

  logic signed [QUAT_WIDTH-1:0] quat_in [NUM_QUAT];
  logic signed [VEC_WIDTH-1:0]  vec_in  [NUM_AXES];

  // matrix -> mac
  logic                         m_vld;
  logic [2*QUAT_WIDTH:0]        m_n2;
  logic signed [DW-1:0]         m_mat [NUM_MAT];
  logic signed [VEC_WIDTH-1:0]  m_vec [NUM_AXES];

  // divider chain, index 0 is the mac output
  logic                         d_vld  [QB+1];
  logic [RW-1:0]                d_rem  [QB+1][NUM_AXES];
  logic [QB-1:0]                d_quo  [QB+1][NUM_AXES];
  logic [NUM_AXES-1:0]          d_neg  [QB+1];
  logic [DW-1:0]                d_den  [QB+1];
  logic                         d_zero [QB+1];
  logic signed [VEC_WIDTH-1:0]  d_vec  [QB+1][NUM_AXES];

  // output stage
  logic [VEC_WIDTH-1:0]         rot_nxt [NUM_AXES];
  logic [NUM_AXES-1:0]          clamp;
  logic [QB-1:0]                half;
  logic                         sat_nxt;
  logic                         out_vld_r;
  logic [VEC_WIDTH-1:0]         rot_r [NUM_AXES];
  logic                         zero_r;
  logic                         sat_r;

  assign adv       = !out_vld_r || out_tready;
  assign in_tready = adv;

  always_comb begin
    for (int i = 0; i < NUM_QUAT; i++) begin
      quat_in[i] = in_tdata[i*QUAT_WIDTH +: QUAT_WIDTH];
    end
    for (int i = 0; i < NUM_AXES; i++) begin
      vec_in[i] = in_tdata[VBASE + i*VEC_WIDTH +: VEC_WIDTH];
    end
  end

  qrv_matrix #(
    .VEC_WIDTH (VEC_WIDTH),
    .QUAT_WIDTH(QUAT_WIDTH)
  ) u_matrix (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_valid (in_tvalid),
    .quat_i   (quat_in),
    .vec_i    (vec_in),
    .out_valid(m_vld),
    .n2_o     (m_n2),
    .mat_o    (m_mat),
    .vec_o    (m_vec)
  );

  qrv_mac #(
    .VEC_WIDTH (VEC_WIDTH),
    .QUAT_WIDTH(QUAT_WIDTH)
  ) u_mac (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_valid (m_vld),
    .n2_i     (m_n2),
    .mat_i    (m_mat),
    .vec_i    (m_vec),
    .out_valid(d_vld[0]),
    .rem_o    (d_rem[0]),
    .neg_o    (d_neg[0]),
    .den_o    (d_den[0]),
    .zero_o   (d_zero[0]),
    .vec_o    (d_vec[0])
  );

  always_comb begin
    for (int c = 0; c < NUM_AXES; c++) begin
      d_quo[0][c] = '0;
    end
  end

  // Quotient resolved MSB first; stage k settles bit QB-1-k.
  for (genvar k = 0; k < QB; k++) begin : g_div
    qrv_div_stage #(
      .VEC_WIDTH (VEC_WIDTH),
      .QUAT_WIDTH(QUAT_WIDTH),
      .STEP      (QB - 1 - k)
    ) u_stage (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (adv),
      .in_valid (d_vld[k]),
      .rem_i    (d_rem[k]),
      .quo_i    (d_quo[k]),
      .neg_i    (d_neg[k]),
      .den_i    (d_den[k]),
      .zero_i   (d_zero[k]),
      .vec_i    (d_vec[k]),
      .out_valid(d_vld[k+1]),
      .rem_o    (d_rem[k+1]),
      .quo_o    (d_quo[k+1]),
      .neg_o    (d_neg[k+1]),
      .den_o    (d_den[k+1]),
      .zero_o   (d_zero[k+1]),
      .vec_o    (d_vec[k+1])
    );
  end

  // Sign restore and clamp. Negative side reaches one step further (-half).
  assign half = QB'(1) << (VEC_WIDTH - 1);

  always_comb begin
    for (int c = 0; c < NUM_AXES; c++) begin
      if (d_neg[QB][c]) begin
        clamp[c]   = (d_quo[QB][c] > half);
        rot_nxt[c] = clamp[c] ? VEC_WIDTH'(half) : VEC_WIDTH'(~d_quo[QB][c] + QB'(1));
      end else begin
        clamp[c]   = (d_quo[QB][c] > (half - QB'(1)));
        rot_nxt[c] = clamp[c] ? VEC_WIDTH'(half - QB'(1)) : VEC_WIDTH'(d_quo[QB][c]);
      end
      // zero quaternion: identity, pass the vector straight through
      if (d_zero[QB]) begin
        rot_nxt[c] = d_vec[QB][c];
      end
    end
    sat_nxt = !d_zero[QB] && (clamp != '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= d_vld[QB];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rot_r  <= rot_nxt;
      zero_r <= d_zero[QB];
      sat_r  <= sat_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = OUT_W'({rot_r[2], rot_r[1], rot_r[0]});
  assign out_tuser  = {sat_r, zero_r};
endmodule
`default_nettype wire

### hw/rtl/qrv_matrix.sv
`default_nettype none
// Two stages: component products, then n2 and the scaled matrix n2 * R.
module qrv_matrix #(
  parameter int VEC_WIDTH  = qrv_pkg::VEC_WIDTH_DEF,
  parameter int QUAT_WIDTH = qrv_pkg::QUAT_WIDTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          en,
  input  wire logic                          in_valid,
  input  wire logic signed [QUAT_WIDTH-1:0]  quat_i [qrv_pkg::NUM_QUAT],
  input  wire logic signed [VEC_WIDTH-1:0]   vec_i  [qrv_pkg::NUM_AXES],
  output logic                               out_valid,
  output logic [2*QUAT_WIDTH:0]              n2_o,
  output logic signed [2*QUAT_WIDTH+1:0]     mat_o  [qrv_pkg::NUM_MAT],
  output logic signed [VEC_WIDTH-1:0]        vec_o  [qrv_pkg::NUM_AXES]
);
  import qrv_pkg::*;

  localparam int PW = 2 * QUAT_WIDTH;
  localparam int MW = 2 * QUAT_WIDTH + 2;
  localparam int NP = 10;
  // product slots
  localparam int XX = 0, YY = 1, ZZ = 2, WW = 3, XY = 4;
  localparam int XZ = 5, YZ = 6, WX = 7, WY = 8, WZ = 9;
  // quaternion slots
  localparam int QX = 0, QY = 1, QZ = 2, QW = 3;

  logic signed [PW-1:0]        prod_nxt [NP];
  logic signed [PW-1:0]        prod_r   [NP];
  logic signed [VEC_WIDTH-1:0] vec1_r   [NUM_AXES];
  logic                        vld1_r;
  logic [PW:0]                 n2_nxt;
  logic [PW:0]                 n2_r;
  logic signed [MW-1:0]        mat_nxt  [NUM_MAT];
  logic signed [MW-1:0]        mat_r    [NUM_MAT];
  logic signed [VEC_WIDTH-1:0] vec2_r   [NUM_AXES];
  logic                        vld2_r;

  always_comb begin
    prod_nxt[XX] = quat_i[QX] * quat_i[QX];
    prod_nxt[YY] = quat_i[QY] * quat_i[QY];
    prod_nxt[ZZ] = quat_i[QZ] * quat_i[QZ];
    prod_nxt[WW] = quat_i[QW] * quat_i[QW];
    prod_nxt[XY] = quat_i[QX] * quat_i[QY];
    prod_nxt[XZ] = quat_i[QX] * quat_i[QZ];
    prod_nxt[YZ] = quat_i[QY] * quat_i[QZ];
    prod_nxt[WX] = quat_i[QW] * quat_i[QX];
    prod_nxt[WY] = quat_i[QW] * quat_i[QY];
    prod_nxt[WZ] = quat_i[QW] * quat_i[QZ];
  end

  always_comb begin
    n2_nxt     = (PW+1)'(prod_r[XX]) + (PW+1)'(prod_r[YY])
               + (PW+1)'(prod_r[ZZ]) + (PW+1)'(prod_r[WW]);
    mat_nxt[0] = MW'(prod_r[WW]) + MW'(prod_r[XX]) - MW'(prod_r[YY]) - MW'(prod_r[ZZ]);
    mat_nxt[1] = (MW'(prod_r[XY]) - MW'(prod_r[WZ])) <<< 1;
    mat_nxt[2] = (MW'(prod_r[XZ]) + MW'(prod_r[WY])) <<< 1;
    mat_nxt[3] = (MW'(prod_r[XY]) + MW'(prod_r[WZ])) <<< 1;
    mat_nxt[4] = MW'(prod_r[WW]) - MW'(prod_r[XX]) + MW'(prod_r[YY]) - MW'(prod_r[ZZ]);
    mat_nxt[5] = (MW'(prod_r[YZ]) - MW'(prod_r[WX])) <<< 1;
    mat_nxt[6] = (MW'(prod_r[XZ]) - MW'(prod_r[WY])) <<< 1;
    mat_nxt[7] = (MW'(prod_r[YZ]) + MW'(prod_r[WX])) <<< 1;
    mat_nxt[8] = MW'(prod_r[WW]) - MW'(prod_r[XX]) - MW'(prod_r[YY]) + MW'(prod_r[ZZ]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
    end else if (en) begin
      vld1_r <= in_valid;
      vld2_r <= vld1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod_nxt;
      vec1_r <= vec_i;
      n2_r   <= n2_nxt;
      mat_r  <= mat_nxt;
      vec2_r <= vec1_r;
    end
  end

  assign out_valid = vld2_r;
  assign n2_o      = n2_r;
  assign mat_o     = mat_r;
  assign vec_o     = vec2_r;
endmodule
`default_nettype wire

### hw/rtl/qrv_mac.sv
`default_nettype none
// Two stages: matrix times vector products, then row sums folded into
// a rounding dividend 2|acc| + n2 and divisor 2 n2.
module qrv_mac #(
  parameter int VEC_WIDTH  = qrv_pkg::VEC_WIDTH_DEF,
  parameter int QUAT_WIDTH = qrv_pkg::QUAT_WIDTH_DEF
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   en,
  input  wire logic                                   in_valid,
  input  wire logic [2*QUAT_WIDTH:0]                  n2_i,
  input  wire logic signed [2*QUAT_WIDTH+1:0]         mat_i [qrv_pkg::NUM_MAT],
  input  wire logic signed [VEC_WIDTH-1:0]            vec_i [qrv_pkg::NUM_AXES],
  output logic                                        out_valid,
  output logic [2*QUAT_WIDTH+VEC_WIDTH+5:0]           rem_o [qrv_pkg::NUM_AXES],
  output logic [qrv_pkg::NUM_AXES-1:0]                neg_o,
  output logic [2*QUAT_WIDTH+1:0]                     den_o,
  output logic                                        zero_o,
  output logic signed [VEC_WIDTH-1:0]                 vec_o [qrv_pkg::NUM_AXES]
);
  import qrv_pkg::*;

  localparam int NW  = 2 * QUAT_WIDTH + 1;
  localparam int MW  = 2 * QUAT_WIDTH + 2;
  localparam int XW  = MW + VEC_WIDTH;
  localparam int AW  = XW + 2;
  localparam int RW  = AW + 2;

  logic signed [XW-1:0]        xp_nxt [NUM_MAT];
  logic signed [XW-1:0]        xp_r   [NUM_MAT];
  logic [NW-1:0]               n2_r;
  logic signed [VEC_WIDTH-1:0] vec3_r [NUM_AXES];
  logic                        vld3_r;
  logic signed [AW-1:0]        acc    [NUM_AXES];
  logic [AW-1:0]               mag    [NUM_AXES];
  logic [RW-1:0]               rem_nxt [NUM_AXES];
  logic [NUM_AXES-1:0]         neg_nxt;
  logic [RW-1:0]               rem_r  [NUM_AXES];
  logic [NUM_AXES-1:0]         neg_r;
  logic [NW:0]                 den_r;
  logic                        zero_r;
  logic signed [VEC_WIDTH-1:0] vec4_r [NUM_AXES];
  logic                        vld4_r;

  always_comb begin
    for (int r = 0; r < NUM_AXES; r++) begin
      for (int c = 0; c < NUM_AXES; c++) begin
        xp_nxt[r*NUM_AXES+c] = mat_i[r*NUM_AXES+c] * vec_i[c];
      end
    end
  end

  always_comb begin
    for (int r = 0; r < NUM_AXES; r++) begin
      acc[r]     = AW'(xp_r[r*NUM_AXES]) + AW'(xp_r[r*NUM_AXES+1])
                 + AW'(xp_r[r*NUM_AXES+2]);
      neg_nxt[r] = acc[r][AW-1];
      mag[r]     = neg_nxt[r] ? AW'(-acc[r]) : AW'(acc[r]);
      // round half away from zero: floor((2|a| + n2) / (2 n2))
      rem_nxt[r] = RW'({mag[r], 1'b0}) + RW'(n2_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld3_r <= 1'b0;
      vld4_r <= 1'b0;
    end else if (en) begin
      vld3_r <= in_valid;
      vld4_r <= vld3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xp_r   <= xp_nxt;
      n2_r   <= n2_i;
      vec3_r <= vec_i;
      rem_r  <= rem_nxt;
      neg_r  <= neg_nxt;
      den_r  <= {n2_r, 1'b0};
      zero_r <= (n2_r == '0);
      vec4_r <= vec3_r;
    end
  end

  assign out_valid = vld4_r;
  assign rem_o     = rem_r;
  assign neg_o     = neg_r;
  assign den_o     = den_r;
  assign zero_o    = zero_r;
  assign vec_o     = vec4_r;
endmodule
`default_nettype wire

### hw/rtl/qrv_div_stage.sv
`default_nettype none
// One restoring-division step per axis: resolves quotient bit STEP.
module qrv_div_stage #(
  parameter int VEC_WIDTH  = qrv_pkg::VEC_WIDTH_DEF,
  parameter int QUAT_WIDTH = qrv_pkg::QUAT_WIDTH_DEF,
  parameter int STEP       = 0
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  en,
  input  wire logic                                  in_valid,
  input  wire logic [2*QUAT_WIDTH+VEC_WIDTH+5:0]     rem_i [qrv_pkg::NUM_AXES],
  input  wire logic [VEC_WIDTH+1:0]                  quo_i [qrv_pkg::NUM_AXES],
  input  wire logic [qrv_pkg::NUM_AXES-1:0]          neg_i,
  input  wire logic [2*QUAT_WIDTH+1:0]               den_i,
  input  wire logic                                  zero_i,
  input  wire logic signed [VEC_WIDTH-1:0]           vec_i [qrv_pkg::NUM_AXES],
  output logic                                       out_valid,
  output logic [2*QUAT_WIDTH+VEC_WIDTH+5:0]          rem_o [qrv_pkg::NUM_AXES],
  output logic [VEC_WIDTH+1:0]                       quo_o [qrv_pkg::NUM_AXES],
  output logic [qrv_pkg::NUM_AXES-1:0]               neg_o,
  output logic [2*QUAT_WIDTH+1:0]                    den_o,
  output logic                                       zero_o,
  output logic signed [VEC_WIDTH-1:0]                vec_o [qrv_pkg::NUM_AXES]
);
  import qrv_pkg::*;

  localparam int RW = 2 * QUAT_WIDTH + VEC_WIDTH + 6;
  localparam int QB = VEC_WIDTH + 2;

  logic [RW-1:0]               dsh;
  logic [NUM_AXES-1:0]         ge;
  logic [RW-1:0]               rem_nxt [NUM_AXES];
  logic [QB-1:0]               quo_nxt [NUM_AXES];
  logic [RW-1:0]               rem_r   [NUM_AXES];
  logic [QB-1:0]               quo_r   [NUM_AXES];
  logic [NUM_AXES-1:0]         neg_r;
  logic [2*QUAT_WIDTH+1:0]     den_r;
  logic                        zero_r;
  logic signed [VEC_WIDTH-1:0] vec_r   [NUM_AXES];
  logic                        vld_r;

  assign dsh = RW'(den_i) << STEP;

  always_comb begin
    for (int c = 0; c < NUM_AXES; c++) begin
      ge[c]            = (rem_i[c] >= dsh);
      rem_nxt[c]       = ge[c] ? (rem_i[c] - dsh) : rem_i[c];
      quo_nxt[c]       = quo_i[c];
      quo_nxt[c][STEP] = ge[c];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r  <= rem_nxt;
      quo_r  <= quo_nxt;
      neg_r  <= neg_i;
      den_r  <= den_i;
      zero_r <= zero_i;
      vec_r  <= vec_i;
    end
  end

  assign out_valid = vld_r;
  assign rem_o     = rem_r;
  assign quo_o     = quo_r;
  assign neg_o     = neg_r;
  assign den_o     = den_r;
  assign zero_o    = zero_r;
  assign vec_o     = vec_r;
endmodule
`default_nettype wire

### hw/rtl/qrv_checker.sv
`default_nettype none
`include "assert_macros.svh"
module qrv_props #(
  parameter int VEC_WIDTH = qrv_pkg::VEC_WIDTH_DEF
) (
  input wire logic                                 clk,
  input wire logic                                 rst_n,
  input wire logic                                 in_tready,
  input wire logic                                 out_tvalid,
  input wire logic                                 out_tready,
  input wire logic [((3*VEC_WIDTH+7)/8)*8-1:0]     out_tdata,
  input wire logic [1:0]                           out_tuser
);
  import qrv_pkg::*;

  // result waiting at the output
  logic stall;
  assign stall = out_tvalid && !out_tready;

  `ASSERT_CLK(a_out_hold, stall |=> out_tvalid, "result dropped while stalled")
  `ASSERT_CLK(a_out_stable, stall |=> $stable({out_tuser, out_tdata}), "stalled result changed")
  `ASSERT_CLK(a_zero_no_sat, out_tvalid && out_tuser[0] |-> !out_tuser[1], "identity clamped")
  `ASSERT_ALWAYS(a_ready_empty, !out_tvalid |-> in_tready, "input blocked with empty output")
endmodule

bind quat_rotate_vector qrv_props #(.VEC_WIDTH(VEC_WIDTH)) u_qrv_props (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tready (in_tready),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .out_tuser (out_tuser)
);
`default_nettype wire

### dv/qrv_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module qrv_checker #(
  parameter int VW = 24,
  parameter int QW = 16
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_tvalid,
  input  wire logic in_tready,
  input  wire logic [((4*QW+3*VW+7)/8)*8-1:0] in_tdata,
  input  wire logic out_tvalid,
  input  wire logic out_tready,
  input  wire logic [((3*VW+7)/8)*8-1:0] out_tdata,
  input  wire logic [1:0] out_tuser,
  output int        fail_count,
  output int        pending,
  output int        rot_count,
  output int        sat_count,
  output int        zq_count
);

  typedef struct packed {
    logic [VW-1:0] rz;
    logic [VW-1:0] ry;
    logic [VW-1:0] rx;
    logic          zq;
    logic          sat;
  } rot_result_t;

  rot_result_t rot_expected_q[$];

  // Exact rotation: (n2 * R * v) / n2, rounded half away from zero, then clamped.
  function automatic rot_result_t rotate_vec(logic [((4*QW+3*VW+7)/8)*8-1:0] d);
    logic signed [QW-1:0] q[4];
    logic signed [VW-1:0] v[3];
    logic signed [127:0]  qq[4][4];
    logic signed [127:0]  n2, acc, mag, quo;
    logic signed [127:0]  vmax, vmin;
    logic signed [VW-1:0] r[3];
    rot_result_t          res;
    logic                 sat;
    vmax = (128'sd1 <<< (VW-1)) - 1;
    vmin = -(128'sd1 <<< (VW-1));
    sat = 1'b0;
    for (int i = 0; i < 4; i++) q[i] = d[i*QW +: QW];
    for (int i = 0; i < 3; i++) v[i] = d[4*QW + i*VW +: VW];
    for (int a = 0; a < 4; a++)
      for (int b = 0; b < 4; b++)
        qq[a][b] = 128'(q[a]) * 128'(q[b]);
    n2 = qq[0][0] + qq[1][1] + qq[2][2] + qq[3][3];
    if (n2 == 0) begin
      res.rx = v[0]; res.ry = v[1]; res.rz = v[2];
      res.zq = 1'b1; res.sat = 1'b0;
      return res;
    end
    for (int i = 0; i < 3; i++) begin
      // indices: x=0 y=1 z=2 w=3
      case (i)
        0: acc = (qq[3][3] + qq[0][0] - qq[1][1] - qq[2][2]) * 128'(v[0])
               + 2 * (qq[0][1] - qq[3][2]) * 128'(v[1])
               + 2 * (qq[0][2] + qq[3][1]) * 128'(v[2]);
        1: acc = 2 * (qq[0][1] + qq[3][2]) * 128'(v[0])
               + (qq[3][3] - qq[0][0] + qq[1][1] - qq[2][2]) * 128'(v[1])
               + 2 * (qq[1][2] - qq[3][0]) * 128'(v[2]);
        default: acc = 2 * (qq[0][2] - qq[3][1]) * 128'(v[0])
               + 2 * (qq[1][2] + qq[3][0]) * 128'(v[1])
               + (qq[3][3] - qq[0][0] - qq[1][1] + qq[2][2]) * 128'(v[2]);
      endcase
      mag = (acc < 0) ? -acc : acc;
      quo = (2 * mag + n2) / (2 * n2);
      if (acc < 0) quo = -quo;
      if (quo > vmax) begin
        sat = 1'b1; quo = vmax;
      end else if (quo < vmin) begin
        sat = 1'b1; quo = vmin;
      end
      r[i] = quo[VW-1:0];
    end
    res.rx = r[0]; res.ry = r[1]; res.rz = r[2];
    res.zq = 1'b0; res.sat = sat;
    return res;
  endfunction

  always_comb pending = rot_expected_q.size();

  always @(posedge clk) begin
    rot_result_t exp_r, got;
    if (!rst_n) begin
      fail_count <= 0;
      rot_count <= 0;
      sat_count <= 0;
      zq_count <= 0;
    end else begin
      if (in_tvalid && in_tready) rot_expected_q.push_back(rotate_vec(in_tdata));
      if (out_tvalid && out_tready) begin
        got.rx = out_tdata[0 +: VW];
        got.ry = out_tdata[VW +: VW];
        got.rz = out_tdata[2*VW +: VW];
        got.zq = out_tuser[0];
        got.sat = out_tuser[1];
        rot_count <= rot_count + 1;
        if (got.sat) sat_count <= sat_count + 1;
        if (got.zq) zq_count <= zq_count + 1;
        if (rot_expected_q.size() == 0) begin
          $display("%0t: unexpected result %h", $time, got);
          fail_count <= fail_count + 1;
        end else begin
          exp_r = rot_expected_q.pop_front();
          if (got !== exp_r) begin
            $display("%0t: mismatch exp x=%h y=%h z=%h zq=%b sat=%b", $time,
                     exp_r.rx, exp_r.ry, exp_r.rz, exp_r.zq, exp_r.sat);
            $display("%0t:          got x=%h y=%h z=%h zq=%b sat=%b", $time,
                     got.rx, got.ry, got.rz, got.zq, got.sat);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule
`default_nettype wire

### dv/quat_rotate_vector_tb.sv
`timescale 1ns / 1ps
`default_nettype none
module quat_rotate_vector_tb;
  localparam int VW = 24;
  localparam int QW = 16;
  localparam int DW = ((4*QW+3*VW+7)/8)*8;
  localparam int OW = ((3*VW+7)/8)*8;
  localparam int LATENCY = VW + 7;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [DW-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OW-1:0] out_tdata;
  logic [1:0] out_tuser;

  int fail_count, pending, rot_count, sat_count, zq_count;
  int send_idle_pct = 0;   // chance per cycle the sender holds off
  int recv_stall_pct = 0;  // chance per cycle the receiver stalls
  int sent = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  quat_rotate_vector #(.VEC_WIDTH(VW), .QUAT_WIDTH(QW)) u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  qrv_checker #(.VW(VW), .QW(QW)) u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser),
    .fail_count(fail_count), .pending(pending), .rot_count(rot_count),
    .sat_count(sat_count), .zq_count(zq_count)
  );

  // Receiver: random backpressure, updated on the falling edge.
  always @(negedge clk) begin
    out_tready <= rst_n && ($urandom_range(99) >= recv_stall_pct);
  end

  function automatic logic [DW-1:0] pack_req(logic [QW-1:0] qx, logic [QW-1:0] qy,
      logic [QW-1:0] qz, logic [QW-1:0] qw, logic [VW-1:0] vx, logic [VW-1:0] vy,
      logic [VW-1:0] vz);
    logic [DW-1:0] d;
    d = '0;
    d[0 +: QW] = qx; d[QW +: QW] = qy; d[2*QW +: QW] = qz; d[3*QW +: QW] = qw;
    d[4*QW +: VW] = vx; d[4*QW+VW +: VW] = vy; d[4*QW+2*VW +: VW] = vz;
    return d;
  endfunction

  // Drive one request; holds it until accepted. Leaves valid high only if
  // the next request follows directly (no idle draw), so no same-step toggle.
  task automatic send_req(logic [DW-1:0] d);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= d;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  function automatic logic [QW-1:0] rand_quat_comp();
    case ($urandom_range(5))
      0: return {1'b1, {(QW-1){1'b0}}};
      1: return {1'b0, {(QW-1){1'b1}}};
      2: return QW'($urandom_range(32)) - QW'(16);
      default: return QW'($urandom);
    endcase
  endfunction

  function automatic logic [VW-1:0] rand_vec_comp();
    case ($urandom_range(5))
      0: return {1'b1, {(VW-1){1'b0}}};
      1: return {1'b0, {(VW-1){1'b1}}};
      2: return VW'($urandom_range(200)) - VW'(100);
      default: return VW'($urandom);
    endcase
  endfunction

  task automatic send_random(int n);
    logic [QW-1:0] q[4];
    for (int k = 0; k < n; k++) begin
      for (int i = 0; i < 4; i++) q[i] = rand_quat_comp();
      // occasional zero quaternion, and axis-only ones
      if ($urandom_range(19) == 0) q = '{default: '0};
      else if ($urandom_range(9) == 0) begin
        q = '{default: '0};
        q[$urandom_range(3)] = rand_quat_comp();
      end
      send_req(pack_req(q[0], q[1], q[2], q[3],
                        rand_vec_comp(), rand_vec_comp(), rand_vec_comp()));
    end
  endtask

  localparam logic [QW-1:0] QONE = QW'(16384);
  localparam logic [QW-1:0] QMAX = {1'b0, {(QW-1){1'b1}}};
  localparam logic [QW-1:0] QMIN = {1'b1, {(QW-1){1'b0}}};
  localparam logic [VW-1:0] VMAX = {1'b0, {(VW-1){1'b1}}};
  localparam logic [VW-1:0] VMIN = {1'b1, {(VW-1){1'b0}}};

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: identity, zero quaternion, axis turns, extremes, saturation.
    send_req(pack_req('0, '0, '0, QONE, 24'd1, 24'd2, 24'd3));
    send_req(pack_req('0, '0, '0, '0, VMAX, VMIN, 24'hFFFFFF));
    send_req(pack_req('0, '0, '0, '0, VMIN, VMAX, 24'd0));
    send_req(pack_req(QONE, '0, '0, '0, VMAX, VMAX, VMIN));
    send_req(pack_req('0, QONE, '0, '0, VMAX, VMIN, VMAX));
    send_req(pack_req('0, '0, QONE, '0, VMIN, VMIN, VMAX));
    send_req(pack_req(QMIN, QMIN, QMIN, QMIN, VMAX, VMAX, VMAX));
    send_req(pack_req(QMAX, QMAX, QMAX, QMAX, VMIN, VMIN, VMIN));
    send_req(pack_req(QMIN, QMAX, '0, '0, VMAX, VMIN, VMAX));
    // 45 degrees about z: pushes a diagonal vector past full scale
    send_req(pack_req('0, '0, QW'(6270), QW'(15137), VMAX, VMAX, 24'd0));
    send_req(pack_req('0, '0, QW'(6270), QW'(15137), VMIN, VMIN, 24'd0));
    send_req(pack_req(QW'(1), '0, '0, '0, 24'd5, 24'd7, 24'h800001));
    send_req(pack_req(QW'(1), QW'(1), '0, '0, 24'd1, 24'd0, 24'd0)); // half turn about the x = y axis
    send_req(pack_req(QW'(1), QW'(1), QW'(1), QW'(1), 24'd1, 24'hFFFFFE, 24'd3));
    send_req(pack_req(QW'(-1), '0, '0, QW'(-1), 24'd3, 24'hFFFFFD, 24'd1));
    send_req(pack_req(QMAX, QMIN, QMAX, QMIN, 24'h555555, 24'hAAAAAA, 24'h0F0F0F));
    // Hold off until the pipe is empty.
    drain();

    send_random(125);
    send_idle_pct = 78;
    send_random(125);
    send_idle_pct = 0;
    recv_stall_pct = 78;
    send_random(125);
    send_idle_pct = 34;
    recv_stall_pct = 34;
    send_random(125);
    send_idle_pct = 0;
    recv_stall_pct = 0;

    drain();
    repeat (LATENCY + 10) @(negedge clk);

    $display("Sent %0d requests; %0d results checked (%0d saturated, %0d zero quaternion).",
             sent, rot_count, sat_count, zq_count);
    $display("Idle/stall phases: none, sender 78%%, receiver 78%%, both 34%%.");
    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog: worst case 516 requests, heavy stalls, plus pipe latency.
  initial begin
    #2_000_000;
    $display("Timeout with %0d results outstanding", pending);
    $display("== FAIL ==");
    $finish;
  end

endmodule
`default_nettype wire
